>>> src/bqs_pkg.sv
// Package for the bounded queue with search: request and response types,
// request kind codes, status codes and default sizing.
// No dependencies.
package bqs_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;

	localparam logic [2:0] K_APPEND = 3'd0;
	localparam logic [2:0] K_REMOVE = 3'd1;
	localparam logic [2:0] K_FIND   = 3'd2;
	localparam logic [2:0] K_READ   = 3'd3;
	localparam logic [2:0] K_CLEAR  = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;

	typedef struct packed {
		logic [2:0]               kind;
		logic signed [WORD_W-1:0] value;
		logic [3:0]               index;
	} req_t;

	typedef struct packed {
		logic [2:0]               status;
		logic [3:0]               position;
		logic signed [WORD_W-1:0] data;
		logic [4:0]               count;
	} rsp_t;

endpackage

>>> src/bqs_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on bqs_pkg.
interface bqs_req_if;
	import bqs_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface bqs_rsp_if;
	import bqs_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

>>> src/bounded_queue_with_search_core.sv
// Append, remove, clear and full/empty/range error results: registered into the output register
// when it is free, else held in a result register until it is; back to back while the output drains.
// Find and in-range read rotate the cell ring once, one cell per cycle; the result is registered
// at the end of the walk, and the next request is taken once the walk is done and the output free.
// One request is in progress at a time; a finished result may wait in the output register.
// Reset clears the count, sequencer state and output valid; stored words are not cleared.
module bounded_queue_with_search_core #(
	parameter int DEPTH = bqs_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	bqs_req_if.sink       req,
	bqs_rsp_if.source     rsp
);

	import bqs_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (IW > 4) ? IW : 4;
	localparam int QW = (CW > 4) ? CW : 4;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     step_q;
	logic [2:0]        kind_q;
	logic [WORD_W-1:0] value_q;
	logic [3:0]        index_q;
	logic              hit_q;
	logic [IW-1:0]     pos_q;
	logic [WORD_W-1:0] rd_q;
	rsp_t              res_q;
	rsp_t              out_q;
	logic              out_valid_q;

	logic [WORD_W-1:0] cell_q [DEPTH];
	logic [DEPTH-1:0]  load_en;
	logic              shift_en;

	logic              accept;
	logic              out_free;
	logic              full;
	logic              empty;
	logic              walk_op;
	logic              app_go;
	logic              rem_go;
	logic [CW-1:0]     count_n;
	rsp_t              imm_res;
	logic              last;
	logic              match;
	logic              hit_n;
	logic [IW-1:0]     pos_n;
	logic              idx_here;
	logic [WORD_W-1:0] rd_n;
	rsp_t              walk_res;
	logic              fin_valid;
	rsp_t              fin_res;
	logic              load_out;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign load_en[gi] = app_go && (count_q == CW'(gi));
			bqs_cell #(.W(WORD_W)) u_cell (
				.clk    (clk),
				.load   (load_en[gi]),
				.shift  (shift_en),
				.load_d (req.payload.value),
				.nbr_d  (cell_q[(gi + 1) % DEPTH]),
				.q      (cell_q[gi])
			);
		end
	endgenerate

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign app_go    = accept && (req.payload.kind == K_APPEND) && !full;
	assign rem_go    = accept && (req.payload.kind == K_REMOVE) && !empty;
	assign shift_en  = (state_q == S_WALK) || rem_go;

	always_comb begin
		count_n         = count_q;
		walk_op         = 1'b0;
		imm_res         = '0;
		imm_res.status  = ST_OK;
		unique case (req.payload.kind)
			K_APPEND: begin
				if (full) begin
					imm_res.status = ST_FULL;
				end else begin
					count_n = count_q + CW'(1);
				end
			end
			K_REMOVE: begin
				if (empty) begin
					imm_res.status = ST_EMPTY;
				end else begin
					count_n = count_q - CW'(1);
				end
			end
			K_FIND: begin
				walk_op = 1'b1;
			end
			K_READ: begin
				if (QW'(req.payload.index) < QW'(count_q)) begin
					walk_op = 1'b1;
				end else begin
					imm_res.status = ST_RANGE;
				end
			end
			K_CLEAR: begin
				count_n = '0;
			end
			default: begin
			end
		endcase
		imm_res.count = 5'(count_n);
	end

	assign last     = (step_q == IW'(DEPTH - 1));
	assign match    = (cell_q[0] == value_q) && (CW'(step_q) < count_q);
	assign hit_n    = hit_q || match;
	assign pos_n    = hit_q ? pos_q : step_q;
	assign idx_here = (XW'(step_q) == XW'(index_q));
	assign rd_n     = idx_here ? cell_q[0] : rd_q;

	always_comb begin
		walk_res       = '0;
		walk_res.count = 5'(count_q);
		if (kind_q == K_FIND) begin
			if (hit_n) begin
				walk_res.status   = ST_OK;
				walk_res.position = 4'(pos_n);
			end else begin
				walk_res.status = ST_NOT_FOUND;
			end
		end else begin
			walk_res.status = ST_OK;
			walk_res.data   = rd_n;
		end
	end

	assign fin_valid = (accept && !walk_op) || ((state_q == S_WALK) && last);
	assign fin_res   = (state_q == S_WALK) ? walk_res : imm_res;
	assign load_out  = out_free && (fin_valid || (state_q == S_DONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_n;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && walk_op) begin
						state_q <= S_WALK;
					end else if (accept && !out_free) begin
						state_q <= S_DONE;
					end
				end
				S_WALK: begin
					if (last) begin
						state_q <= out_free ? S_IDLE : S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= req.payload.kind;
			value_q <= req.payload.value;
			index_q <= req.payload.index;
			step_q  <= '0;
			hit_q   <= 1'b0;
		end else if (state_q == S_WALK) begin
			step_q <= step_q + IW'(1);
			hit_q  <= hit_n;
			pos_q  <= pos_n;
			rd_q   <= rd_n;
		end
		if (fin_valid && !out_free) begin
			res_q <= fin_res;
		end
		if (load_out) begin
			out_q <= (state_q == S_DONE) ? res_q : fin_res;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

endmodule

>>> src/bqs_cell.sv
// One storage cell of the queue ring: loads a new word or takes its
// neighbor's word. No package dependency.
module bqs_cell #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         load,
	input  logic         shift,
	input  logic [W-1:0] load_d,
	input  logic [W-1:0] nbr_d,
	output logic [W-1:0] q
);

	logic [W-1:0] word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= load_d;
		end else if (shift) begin
			word_q <= nbr_d;
		end
	end

	assign q = word_q;

endmodule

>>> src/bqs_checker.sv
// Port-level checks for the bounded queue with search, bound to the top level.
// Depends on bqs_pkg and bounded_queue_with_search_core.
module bqs_checker #(
	parameter int DEPTH = bqs_pkg::DEPTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input bqs_pkg::rsp_t rsp_payload
);

	import bqs_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("response dropped or changed while stalled");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_payload.status == ST_FULL) |-> rsp_payload.count == 5'(DEPTH))
		else $error("full status with count below depth");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_payload.status == ST_EMPTY) |-> rsp_payload.count == 5'd0)
		else $error("empty status with nonzero count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_payload.status != ST_OK)
		|-> (rsp_payload.data == '0) && (rsp_payload.position == 4'd0))
		else $error("error result carries data or position");

endmodule

bind bounded_queue_with_search_core bqs_checker #(.DEPTH(DEPTH)) u_bqs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
